/* src/tspr_pkg.sv */
package tspr_pkg;

    localparam int ADDR_W      = 5;
    localparam int MAP_MAX     = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] REG_PACKET_MODE  = 3'd0;
    localparam logic [2:0] REG_APPEND_TS    = 3'd1;
    localparam logic [2:0] REG_TS_START     = 3'd2;
    localparam logic [2:0] REG_TS_STEP      = 3'd3;
    localparam logic [2:0] REG_MAP_ENTRY_0  = 3'd4;

    localparam logic [29:0] TS_START_RESET  = 30'h1951D2E;
    localparam logic [29:0] TS_STEP_RESET   = 30'h1F2;
    localparam logic [31:0] NULL_HDR        = 32'h471FFF10;
    localparam logic [31:0] STUFF_WORD      = 32'hFFFFFFFF;

    localparam logic [5:0] LEN188_LAST      = 6'd46;
    localparam logic [5:0] LEN192_LAST      = 6'd47;

    localparam int MAP_VALID_BIT = 26;

    typedef logic [26:0] map_entry_t;

    typedef struct packed {
        logic [1:0]                 packet_mode;
        logic                       append_timestamp;
        logic [29:0]                timestamp_start;
        logic [29:0]                timestamp_step;
        logic [MAP_MAX-1:0][26:0]   map_entry;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_HDR_DATA,
        CMD_PAD,
        CMD_DONE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] word;
        logic [31:0] hdr;
        logic        fin;
    } cmd_t;

endpackage

/* src/ts_packet_pid_remap_atc.sv */
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_operation, s_in_word
// m_        out  m_valid/m_ready    m_out_word, m_last_of_run, m_finished
// apb       in   psel/penable       pwrite, paddr, pwdata, prdata, pready
//
// One data word per cycle in while the queue has room; an output word per cycle out when m_ready is high.
// Inserted headers make two words and a padding finish 48, so the output port
// sets the rate then; a four-entry request queue lets the input run ahead.
// aresetn is synchronous, active low; it clears positions, counts and queue.
// Stalling m_ready backs up the queue, and s_ready drops only when it is full.
module ts_packet_pid_remap_atc
    import tspr_pkg::*;
#(
    parameter int MAP_ENTRIES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [31:0]       s_in_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_out_word,
    output logic              m_last_of_run,
    output logic              m_finished,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t cfg;
    logic ts_load, push, q_full, q_valid, pop;
    cmd_t push_cmd, head;

    assign pready = 1'b1;

    tspr_regs #(.MAP_ENTRIES(MAP_ENTRIES)) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .cfg_o     (cfg),
        .ts_load_o (ts_load)
    );

    tspr_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_i       (cfg),
        .ts_load_i   (ts_load),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_in_word   (s_in_word),
        .push_o      (push),
        .push_cmd_o  (push_cmd),
        .q_full_i    (q_full)
    );

    tspr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_i     (push),
        .push_cmd_i (push_cmd),
        .full_o     (q_full),
        .valid_o    (q_valid),
        .head_o     (head),
        .pop_i      (pop)
    );

    tspr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid_i     (q_valid),
        .q_head_i      (head),
        .pop_o         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_last_of_run (m_last_of_run),
        .m_finished    (m_finished)
    );

endmodule

/* src/tspr_regs.sv */
module tspr_regs
    import tspr_pkg::*;
#(
    parameter int MAP_ENTRIES = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output cfg_t              cfg_o,
    output logic              ts_load_o
);

    logic [1:0]                   mode_reg;
    logic                         append_reg;
    logic [29:0]                  ts_start_reg;
    logic [29:0]                  ts_step_reg;
    logic [MAP_ENTRIES-1:0][26:0] map_reg;
    logic                         ts_load_reg;
    wire  [MAP_MAX-1:0][26:0]     map_all;
    logic                         wr;
    logic [2:0]                   idx;

    assign idx = paddr[ADDR_W-1:2];
    assign wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= '0;
            append_reg   <= 1'b0;
            ts_start_reg <= TS_START_RESET;
            ts_step_reg  <= TS_STEP_RESET;
            map_reg      <= '0;
        end else if (wr) begin
            if (idx == REG_PACKET_MODE) mode_reg     <= pwdata[1:0];
            if (idx == REG_APPEND_TS)   append_reg   <= pwdata[0];
            if (idx == REG_TS_START)    ts_start_reg <= pwdata[29:0];
            if (idx == REG_TS_STEP)     ts_step_reg  <= pwdata[29:0];
            for (int i = 0; i < MAP_ENTRIES; i++) begin
                if (idx == REG_MAP_ENTRY_0 + 3'(i)) map_reg[i] <= pwdata[26:0];
            end
        end
    end

    // counter reloads in the cycle after the write, once the new start value is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_load_reg <= 1'b0;
        end else begin
            ts_load_reg <= wr && (idx == REG_TS_START);
        end
    end

    // entries past the configured count read as invalid
    for (genvar g = 0; g < MAP_MAX; g++) begin : g_map
        if (g < MAP_ENTRIES) begin : g_used
            assign map_all[g] = map_reg[g];
        end else begin : g_unused
            assign map_all[g] = '0;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_PACKET_MODE: prdata = {30'd0, mode_reg};
            REG_APPEND_TS:   prdata = {31'd0, append_reg};
            REG_TS_START:    prdata = {2'd0, ts_start_reg};
            REG_TS_STEP:     prdata = {2'd0, ts_step_reg};
            default:         prdata = {5'd0, map_all[idx[1:0]]};
        endcase
    end

    assign cfg_o.packet_mode      = mode_reg;
    assign cfg_o.append_timestamp = append_reg;
    assign cfg_o.timestamp_start  = ts_start_reg;
    assign cfg_o.timestamp_step   = ts_step_reg;
    assign cfg_o.map_entry        = map_all;
    assign ts_load_o              = ts_load_reg;

endmodule

/* src/tspr_front.sv */
module tspr_front
    import tspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg_i,
    input  logic        ts_load_i,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_in_word,
    output logic        push_o,
    output cmd_t        push_cmd_o,
    input  logic        q_full_i
);

    logic [5:0]  pos_reg, pos_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [29:0] ts_reg,  ts_next;

    logic        accept, src192, dst192, pad_due, last, ins, drop, use_hdr;
    logic [4:0]  cnt_inc;
    logic [12:0] pid, new_pid;
    logic [31:0] data_word, hdr_word;

    assign src192  = cfg_i.packet_mode[0];
    assign dst192  = cfg_i.packet_mode[1];
    assign s_ready = !q_full_i;
    assign accept  = s_valid && s_ready;
    assign cnt_inc = cnt_reg + 5'd1;

    // highest matching entry wins
    always_comb begin
        pid     = s_in_word[20:8];
        new_pid = pid;
        for (int i = 0; i < MAP_MAX; i++) begin
            if (cfg_i.map_entry[i][MAP_VALID_BIT] && cfg_i.map_entry[i][25:13] == pid)
                new_pid = cfg_i.map_entry[i][12:0];
        end
    end

    always_comb begin
        pad_due  = !src192 && dst192 && (cnt_reg != 5'd0);
        last     = pos_reg >= (src192 ? LEN192_LAST : LEN188_LAST);
        ins      = (pos_reg == 6'd0) && !src192 && dst192;
        drop     = (pos_reg == 6'd0) && src192 && !dst192;
        hdr_word = cfg_i.append_timestamp ? {2'b00, ts_reg} : 32'd0;

        data_word = s_in_word;
        if (pos_reg == {5'd0, src192}) data_word = {s_in_word[31:21], new_pid, s_in_word[7:0]};

        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        use_hdr    = 1'b0;
        push_o     = 1'b0;
        push_cmd_o = '{kind: CMD_DONE, word: data_word, hdr: hdr_word, fin: 1'b1};

        if (accept) begin
            if (s_operation) begin
                pos_next = 6'd0;
                push_o   = 1'b1;
                if (pad_due) begin
                    use_hdr         = 1'b1;
                    cnt_next        = cnt_inc;
                    push_cmd_o.kind = CMD_PAD;
                    push_cmd_o.fin  = (cnt_inc == 5'd0);
                end
            end else begin
                push_o   = !drop;
                use_hdr  = ins;
                pos_next = last ? 6'd0 : pos_reg + 6'd1;
                if (last) cnt_next = cnt_inc;
                push_cmd_o.kind = ins ? CMD_HDR_DATA : CMD_DATA;
                push_cmd_o.fin  = 1'b0;
            end
        end

        ts_next = ts_reg;
        if (ts_load_i) ts_next = cfg_i.timestamp_start;
        else if (use_hdr && cfg_i.append_timestamp) ts_next = ts_reg + cfg_i.timestamp_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            cnt_reg <= '0;
            ts_reg  <= TS_START_RESET;
        end else begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
            ts_reg  <= ts_next;
        end
    end

endmodule

/* src/tspr_queue.sv */
module tspr_queue
    import tspr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_i,
    input  cmd_t push_cmd_i,
    output logic full_o,
    output logic valid_o,
    output cmd_t head_o,
    input  logic pop_i
);

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full_o  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid_o = (count_reg != '0);
    assign head_o  = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push_i) mem[wptr_reg] <= push_cmd_i;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push_i) wptr_reg <= wptr_reg + 1'b1;
            if (pop_i)  rptr_reg <= rptr_reg + 1'b1;
            if (push_i && !pop_i)      count_reg <= count_reg + 1'b1;
            else if (pop_i && !push_i) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* src/tspr_back.sv */
module tspr_back
    import tspr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid_i,
    input  cmd_t        q_head_i,
    output logic        pop_o,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_word,
    output logic        m_last_of_run,
    output logic        m_finished
);

    logic [5:0]  beat_reg, beat_next;
    logic        valid_reg, valid_next;
    logic [31:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic        fin_reg,  fin_next;

    logic        load, final_beat;
    logic [5:0]  last_beat;

    always_comb begin
        unique case (q_head_i.kind)
            CMD_PAD:      last_beat = LEN192_LAST;
            CMD_HDR_DATA: last_beat = 6'd1;
            default:      last_beat = 6'd0;
        endcase
        load       = q_valid_i && (!valid_reg || m_ready);
        final_beat = (beat_reg == last_beat);
        pop_o      = load && final_beat;

        word_next  = word_reg;
        last_next  = last_reg;
        fin_next   = fin_reg;
        beat_next  = beat_reg;
        valid_next = valid_reg && !m_ready;

        if (load) begin
            valid_next = 1'b1;
            beat_next  = final_beat ? 6'd0 : beat_reg + 6'd1;
            last_next  = final_beat;
            fin_next   = final_beat && q_head_i.fin;
            unique case (q_head_i.kind)
                CMD_DATA:     word_next = q_head_i.word;
                CMD_HDR_DATA: word_next = (beat_reg == 6'd0) ? q_head_i.hdr : q_head_i.word;
                CMD_PAD: begin
                    if (beat_reg == 6'd0)      word_next = q_head_i.hdr;
                    else if (beat_reg == 6'd1) word_next = NULL_HDR;
                    else                       word_next = STUFF_WORD;
                end
                default:      word_next = 32'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        last_reg <= last_next;
        fin_reg  <= fin_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_word    = word_reg;
    assign m_last_of_run = last_reg;
    assign m_finished    = fin_reg;

endmodule

/* tb/tspr_tb_pkg.sv */
package tspr_tb_pkg;

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

endpackage

/* tb/tspr_stream_check.sv */
module tspr_stream_check
    import tspr_pkg::*;
    import tspr_tb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_operation,
    input  logic [31:0]       s_in_word,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [31:0]       m_out_word,
    input  logic              m_last_of_run,
    input  logic              m_finished,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                errors,
    output int                pending
);

    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        fin;
    } out_word_t;

    out_word_t   expected_words[$];
    out_word_t   want;

    logic [1:0]  pk_mode;
    logic        ts_on;
    logic [29:0] ts_incr;
    map_entry_t  pid_map [MAP_MAX];

    logic [5:0]  word_pos;
    logic [29:0] ts_now;
    logic [4:0]  pkt_count;

    function automatic void queue_word(input out_word_t w);
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic logic [31:0] take_timestamp();
        logic [31:0] w;
        w = '0;
        if (ts_on) begin
            w      = {2'b00, ts_now};
            ts_now = ts_now + ts_incr;
        end
        return w;
    endfunction

    // highest-numbered valid entry that matches wins
    function automatic logic [31:0] remap_pid(input logic [31:0] w);
        logic [12:0] pid;
        logic [12:0] new_pid;
        pid     = w[20:8];
        new_pid = pid;
        for (int i = 0; i < MAP_MAX; i++)
            if (pid_map[i][MAP_VALID_BIT] && pid_map[i][25:13] == pid)
                new_pid = pid_map[i][12:0];
        return {w[31:21], new_pid, w[7:0]};
    endfunction

    task automatic predict_request(input logic op, input logic [31:0] w);
        logic src192;
        logic dst192;
        int   len;
        src192 = pk_mode[0];
        dst192 = pk_mode[1];
        if (op == OP_FINISH) begin
            word_pos = '0;
            if (!src192 && dst192 && pkt_count != 5'd0) begin
                // one null packet towards the 32-packet boundary
                queue_word({take_timestamp(), 2'b00});
                queue_word({NULL_HDR, 2'b00});
                repeat (45) queue_word({STUFF_WORD, 2'b00});
                pkt_count = pkt_count + 5'd1;
                queue_word({STUFF_WORD, 1'b1, pkt_count == 5'd0});
            end else begin
                queue_word({32'h0, 2'b11});
            end
        end else begin
            len = src192 ? 48 : 47;
            if (word_pos == 6'd0 && !src192 && dst192)
                queue_word({take_timestamp(), 2'b00});
            // leading arrival header is dropped going 192 to 188
            if (!(word_pos == 6'd0 && src192 && !dst192))
                queue_word({(word_pos == {5'd0, src192}) ? remap_pid(w) : w, 2'b10});
            if (int'(word_pos) + 1 >= len) begin
                word_pos  = '0;
                pkt_count = pkt_count + 5'd1;
            end else begin
                word_pos = word_pos + 6'd1;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            errors    = 0;
            pk_mode   = '0;
            ts_on     = 1'b0;
            ts_incr   = TS_STEP_RESET;
            ts_now    = TS_START_RESET;
            for (int i = 0; i < MAP_MAX; i++)
                pid_map[i] = '0;
            word_pos  = '0;
            pkt_count = '0;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_PACKET_MODE: pk_mode = pwdata[1:0];
                    REG_APPEND_TS:   ts_on   = pwdata[0];
                    REG_TS_START:    ts_now  = pwdata[29:0];
                    REG_TS_STEP:     ts_incr = pwdata[29:0];
                    default:         pid_map[2'(paddr[ADDR_W-1:2] - REG_MAP_ENTRY_0)] =
                                         pwdata[26:0];
                endcase
            end
            if (s_valid && s_ready)
                predict_request(s_operation, s_in_word);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("check: unexpected result word %08h last %0b finished %0b",
                                 m_out_word, m_last_of_run, m_finished);
                end else begin
                    want = expected_words.pop_front();
                    if (m_out_word !== want.word || m_last_of_run !== want.last ||
                        m_finished !== want.fin) begin
                        errors++;
                        if (errors <= 10)
                            $display({"check: mismatch: expected word %08h last %0b fin %0b,",
                                      " got word %08h last %0b fin %0b"},
                                     want.word, want.last, want.fin,
                                     m_out_word, m_last_of_run, m_finished);
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

/* tb/tb.sv */
module tb;
    import tspr_pkg::*;
    import tspr_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 8;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_operation;
    logic [31:0]       s_in_word;
    logic              m_valid;
    logic              m_ready;
    logic [31:0]       m_out_word;
    logic              m_last_of_run;
    logic              m_finished;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int errors;
    int pending;
    int cycle_count;
    int stall_left;
    bit jitter;
    int pkt_pos;
    int n_sent;
    int n_finish;
    int n_settings;

    logic [1:0]  cur_mode;
    logic        cur_ts_on;
    logic [29:0] cur_start;
    logic [29:0] cur_step;
    map_entry_t  map_cfg [MAP_MAX];

    ts_packet_pid_remap_atc dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_in_word     (s_in_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_last_of_run (m_last_of_run),
        .m_finished    (m_finished),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tspr_stream_check stream_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_in_word     (s_in_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_word    (m_out_word),
        .m_last_of_run (m_last_of_run),
        .m_finished    (m_finished),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // random receiver back-pressure in bursts while jitter is set
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (jitter && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_settings();
        apb_write(REG_PACKET_MODE, 32'(cur_mode));
        apb_write(REG_APPEND_TS, 32'(cur_ts_on));
        apb_write(REG_TS_START, 32'(cur_start));
        apb_write(REG_TS_STEP, 32'(cur_step));
        for (int i = 0; i < MAP_MAX; i++)
            apb_write(REG_MAP_ENTRY_0 + 3'(i), 32'(map_cfg[i]));
        n_settings++;
    endtask

    task automatic send_request(input logic op, input logic [31:0] w);
        if (jitter && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_in_word   <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        n_sent++;
        if (op == OP_FINISH) begin
            n_finish++;
            pkt_pos = 0;
        end else begin
            pkt_pos = (pkt_pos + 1 >= (cur_mode[0] ? 48 : 47)) ? 0 : pkt_pos + 1;
        end
    endtask

    // block idle: nothing outstanding, then room for a dropped word to clear
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // sync byte and a PID, mostly one the map knows, in the TS header word
    function automatic logic [31:0] shaped_word();
        logic [31:0] w;
        logic [12:0] pid;
        w   = $urandom;
        pid = ($urandom_range(0, 2) != 0) ? map_cfg[$urandom_range(0, MAP_MAX - 1)][25:13]
                                          : 13'($urandom);
        if (pkt_pos == int'(cur_mode[0]))
            w = {8'h47, w[23:21], pid, w[7:0]};
        return w;
    endfunction

    function automatic logic [29:0] pick_ts();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return 30'($urandom);
        endcase
    endfunction

    task automatic randomise_settings(input logic [1:0] mode);
        logic [12:0] src;
        cur_mode  = mode;
        cur_ts_on = 1'($urandom_range(0, 1));
        cur_start = pick_ts();
        cur_step  = pick_ts();
        for (int i = 0; i < MAP_MAX; i++) begin
            case ($urandom_range(0, 3))
                0:       src = '0;
                1:       src = '1;
                2:       src = 13'h0100;
                default: src = 13'($urandom);
            endcase
            map_cfg[i] = {1'($urandom_range(0, 3) != 0), src, 13'($urandom)};
            if ($urandom_range(0, 9) == 0)
                map_cfg[i] = '1;
        end
        load_settings();
    endtask

    task automatic random_phase(input logic [1:0] mode, input int n_words,
                                input bit lead_finish, input bit trail_finish);
        wait_idle();
        randomise_settings(mode);
        if (lead_finish)
            send_request(OP_FINISH, $urandom);
        for (int k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 99) == 0)
                send_request(OP_FINISH, $urandom);
            send_request(OP_DATA, shaped_word());
        end
        if (trail_finish)
            send_request(OP_FINISH, $urandom);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_DATA;
        s_in_word   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        jitter      = 1'b1;
        pkt_pos     = 0;
        n_sent      = 0;
        n_finish    = 0;
        n_settings  = 0;
        cur_mode    = 2'b00;
        for (int i = 0; i < MAP_MAX; i++)
            map_cfg[i] = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: pass-through 188, empty map, nothing to pad
        send_request(OP_FINISH, '1);
        send_request(OP_DATA, {8'h47, 3'b010, 13'h1FFF, 8'h10});
        send_request(OP_DATA, '0);
        send_request(OP_DATA, '1);
        send_request(OP_FINISH, '0);

        // 188 to 192, timestamp at its top wrapping by the largest step,
        // overlapping entries so the higher one must win
        wait_idle();
        cur_mode   = 2'b10;
        cur_ts_on  = 1'b1;
        cur_start  = '1;
        cur_step   = '1;
        map_cfg[0] = {1'b1, 13'h1FFF, 13'h0000};
        map_cfg[1] = {1'b1, 13'h1FFF, 13'h0ABC};
        map_cfg[2] = {1'b1, 13'h0000, 13'h1FFF};
        map_cfg[3] = {1'b0, 13'h0100, 13'h0042};
        load_settings();
        send_request(OP_DATA, {8'h47, 3'b111, 13'h1FFF, 8'hFF});
        send_request(OP_DATA, {8'h47, 3'b000, 13'h1FFF, 8'h00});
        send_request(OP_FINISH, $urandom);
        send_request(OP_DATA, 32'h4700_0010);
        send_request(OP_DATA, '1);

        // 192 to 188: arrival header dropped, PID sits in the second word
        wait_idle();
        cur_mode = 2'b01;
        map_cfg[3][MAP_VALID_BIT] = 1'b1;
        load_settings();
        send_request(OP_FINISH, $urandom);
        send_request(OP_DATA, $urandom);
        send_request(OP_DATA, {8'h47, 3'b100, 13'h0100, 8'h1F});
        send_request(OP_DATA, $urandom);

        wait_idle();
        cur_mode  = 2'b11;
        cur_ts_on = 1'b0;
        cur_start = '0;
        cur_step  = '0;
        load_settings();
        send_request(OP_FINISH, $urandom);
        send_request(OP_DATA, $urandom);
        send_request(OP_DATA, 32'h4700_0020);
        send_request(OP_DATA, $urandom);

        // a 192-byte packet left at its last word, so 188 to 192 cuts it short
        wait_idle();
        randomise_settings(2'b01);
        send_request(OP_FINISH, $urandom);
        repeat (47) send_request(OP_DATA, shaped_word());

        // one packet counted, then finishes pad up to the 32-packet boundary
        // and one more finds the stream aligned
        wait_idle();
        cur_mode  = 2'b10;
        cur_ts_on = 1'b1;
        cur_start = pick_ts();
        cur_step  = 30'($urandom);
        load_settings();
        send_request(OP_DATA, shaped_word());
        repeat (32) send_request(OP_FINISH, $urandom);

        random_phase(2'b11, 10, 1'b1, 1'($urandom_range(0, 1)));
        jitter = 1'b0;
        random_phase(2'($urandom_range(0, 3)), 10, 1'b1, 1'b1);

        wait_idle();
        $display("summary: %0d requests (%0d finish) under %0d register settings",
                 n_sent, n_finish, n_settings);
        $display("summary: all packet modes, map hits, timestamp wrap, 32-packet padding");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
